// ===== hw/rtl/buddy_page_allocator_defines.svh =====
// Assertion macros for the buddy page allocator.
// No dependencies; included by the top level.
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BPA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define BPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bpa_pkg.sv =====
// Shared types, constants and address helpers of the buddy page allocator.
// No dependencies.
package bpa_pkg;

  localparam int ORDER    = 10;
  localparam int PW       = ORDER;          // page index width
  localparam int NW       = ORDER + 1;      // page count width
  localparam int SW       = ORDER + 1;      // store / bitmap address width
  localparam int SLOTS    = 2 << ORDER;
  localparam int POOL     = 1 << ORDER;
  localparam int OW       = $clog2(ORDER + 2);
  localparam int PSW      = 17;
  localparam int SZW      = 32;
  localparam int LW       = PSW + ORDER;
  localparam int CW       = (SZW > LW) ? SZW : LW;
  localparam int AW       = 3;              // APB address width
  localparam int DW       = 32;
  localparam logic [PSW-1:0] PS_RESET = PSW'(4096);
  localparam logic KIND_FREE = 1'b1;

  typedef struct packed {
    logic           kind;
    logic [SZW-1:0] size_bytes;
    logic [PW-1:0]  page_id;
    logic [NW-1:0]  num_pages;
  } bpa_in_t;

  typedef struct packed {
    logic          ok;
    logic [PW-1:0] block_page;
    logic [NW-1:0] block_pages;
  } bpa_out_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_ORD, OP_FIND, OP_POP, OP_SPLIT,
    OP_BRD, OP_MSET, OP_BNEXT, OP_FCHK, OP_MGRD, OP_LRD, OP_LNEXT,
    OP_SHRD, OP_SHWR, OP_RMDONE, OP_PUSH, OP_ICLR, OP_IRD0, OP_IRD1,
    OP_ICHK, OP_OK, OP_FAIL, OP_EMIT
  } bpa_op_e;

  typedef struct packed {
    logic clear_last;
    logic kind_free;
    logic size_zero;
    logic ord_hit;
    logic i_top;
    logic i_ord;
    logic j_wrap;
    logic list_nz;
    logic o_top;
    logic o_gt_want;
    logic bit_set;
    logic free_bad;
    logic k_end;
    logic match;
    logic sh_more;
    logic out_free;
  } bpa_status_t;

  // first slot of the region owned by order o
  function automatic logic [SW-1:0] rbase(logic [OW-1:0] o);
    if (int'(o) > ORDER) return '0;
    return SW'(SLOTS - (2 << (ORDER - int'(o))));
  endfunction

  function automatic logic [SW-1:0] lmask(logic [OW-1:0] o);
    if (int'(o) > ORDER) return '0;
    return SW'((1 << (ORDER - int'(o))) - 1);
  endfunction

  function automatic logic [NW-1:0] lcap(logic [OW-1:0] o);
    if (int'(o) > ORDER) return '0;
    return NW'(1 << (ORDER - int'(o)));
  endfunction

  // exact ceil(log2(n)), n >= 1
  function automatic logic [OW-1:0] clog2n(logic [NW-1:0] n);
    logic [OW-1:0] r;
    r = OW'(ORDER + 1);
    for (int k = ORDER; k >= 0; k--) begin
      if ((32'(1) << k) >= 32'(n)) r = OW'(k);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/bpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bpa_ctrl.sv =====
// Sequencer of the buddy page allocator: walks each request through its steps.
// Depends on bpa_pkg.
module bpa_ctrl import bpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  bpa_status_t st_i,
  output bpa_op_e     op_o,
  output logic        in_stall_o
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISP, S_ORD, S_FIND, S_POP, S_SPLIT, S_MRD, S_MCHK,
    S_FCHK, S_BRD, S_BCHK, S_MG, S_MGB, S_LRD, S_LCHK, S_SH, S_SHW, S_PUSH,
    S_IC, S_IR0, S_IR1, S_ICK, S_OK, S_FAIL, S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      S_INIT: begin
        op_o = OP_CLEAR;
        if (st_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP: state_d = st_i.kind_free ? S_FCHK : S_ORD;
      // allocate
      S_ORD: begin
        if (st_i.size_zero) state_d = S_FAIL;
        else if (st_i.ord_hit) begin
          op_o    = OP_ORD;
          state_d = S_FIND;
        end else if (st_i.i_top) state_d = S_FAIL;
        else op_o = OP_ORD;
      end
      S_FIND: begin
        if (st_i.list_nz) begin
          op_o    = OP_FIND;
          state_d = S_POP;
        end else if (st_i.o_top) state_d = S_FAIL;
        else op_o = OP_FIND;
      end
      S_POP: begin
        op_o    = OP_POP;
        state_d = S_SPLIT;
      end
      S_SPLIT: begin
        if (st_i.o_gt_want) op_o = OP_SPLIT;
        else state_d = S_MRD;
      end
      S_MRD: begin
        op_o    = OP_BRD;
        state_d = S_MCHK;
      end
      S_MCHK: begin
        if (st_i.bit_set) state_d = S_OK;
        else begin
          op_o    = OP_MSET;
          state_d = (st_i.j_wrap && st_i.i_top) ? S_OK : S_MRD;
        end
      end
      // free
      S_FCHK: begin
        if (st_i.free_bad) state_d = S_FAIL;
        else begin
          op_o    = OP_FCHK;
          state_d = S_BRD;
        end
      end
      S_BRD: begin
        op_o    = OP_BRD;
        state_d = S_BCHK;
      end
      S_BCHK: begin
        if (!st_i.bit_set) state_d = S_FAIL;
        else begin
          op_o    = OP_BNEXT;
          state_d = (st_i.j_wrap && st_i.i_ord) ? S_MG : S_BRD;
        end
      end
      S_MG: begin
        if (st_i.o_top) state_d = S_PUSH;
        else begin
          op_o    = OP_MGRD;
          state_d = S_MGB;
        end
      end
      S_MGB:  state_d = st_i.bit_set ? S_PUSH : S_LRD;
      S_LRD: begin
        if (st_i.k_end) state_d = S_PUSH;
        else begin
          op_o    = OP_LRD;
          state_d = S_LCHK;
        end
      end
      S_LCHK: begin
        if (st_i.match) state_d = S_SH;
        else begin
          op_o    = OP_LNEXT;
          state_d = S_LRD;
        end
      end
      S_SH: begin
        if (st_i.sh_more) begin
          op_o    = OP_SHRD;
          state_d = S_SHW;
        end else begin
          op_o    = OP_RMDONE;
          state_d = S_MG;
        end
      end
      S_SHW: begin
        op_o    = OP_SHWR;
        state_d = S_SH;
      end
      S_PUSH: begin
        op_o    = OP_PUSH;
        state_d = S_IC;
      end
      S_IC: begin
        op_o = OP_ICLR;
        if (st_i.j_wrap && st_i.i_ord) state_d = st_i.i_top ? S_OK : S_IR0;
      end
      S_IR0: begin
        op_o    = OP_IRD0;
        state_d = S_IR1;
      end
      S_IR1: begin
        op_o    = OP_IRD1;
        state_d = S_ICK;
      end
      S_ICK: begin
        op_o    = OP_ICHK;
        state_d = st_i.i_top ? S_OK : S_IR0;
      end
      S_OK: begin
        op_o    = OP_OK;
        state_d = S_DONE;
      end
      S_FAIL: begin
        op_o    = OP_FAIL;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (st_i.out_free) begin
          op_o    = OP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/bpa_dp.sv =====
// Datapath of the buddy page allocator: request, loop counters, list pointers,
// free-list store and busy bitmap RAMs, result register. Depends on bpa_pkg, bpa_ram.
module bpa_dp import bpa_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bpa_op_e        op_i,
  output bpa_status_t    st_o,
  input  bpa_in_t        in_word_i,
  output bpa_out_t       out_word_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  logic           cfg_we_i,
  input  logic [PSW-1:0] cfg_wdata_i,
  output logic [PSW-1:0] page_size_o
);

  logic [PSW-1:0] ps_q;
  logic           kind_q;
  logic [SZW-1:0] size_q;
  logic [PW-1:0]  pid_q, cur_q;
  logic [NW-1:0]  np_q;
  logic [OW-1:0]  want_q, o_q, i_q;
  logic [NW-1:0]  j_q, k_q;
  logic [PW-1:0]  head_q [ORDER+1];
  logic [NW-1:0]  cnt_q  [ORDER+1];
  logic           c0_q;
  logic [SW-1:0]  clr_q;
  bpa_out_t       res_q, out_q;
  logic           out_valid_q;

  // RAM ports
  logic           st_we, bm_we, bm_wdata;
  logic [SW-1:0]  st_addr, bm_waddr, bm_raddr;
  logic [PW-1:0]  st_wdata, st_rdata;
  logic           bm_rdata;

  logic [PSW-1:0] ps_eff;
  logic [NW-1:0]  pages, lim_raw, lim, j_inc;
  logic [PW-1:0]  base, buddy, buddy_page;
  logic [SW-1:0]  bidx, bit_addr, pidx, c0_addr, c1_addr, buddy_addr, slot;
  logic [OW-1:0]  im1, onew, sel_o, ordf;
  logic [NW-1:0]  cnt_sel, sel_k;
  logic [PW-1:0]  head_sel;
  logic           full;
  logic [NW:0]    pagesf;

  always_comb begin
    ps_eff   = (ps_q == '0) ? PSW'(1) : ps_q;
    pages    = NW'(1) << want_q;
    lim_raw  = pages >> i_q;
    lim      = (lim_raw == '0) ? NW'(1) : lim_raw;
    j_inc    = j_q + NW'(1);
    base     = (kind_q == KIND_FREE) ? pid_q : cur_q;
    bidx     = SW'(base >> i_q) + SW'(j_q);
    bit_addr = rbase(i_q) + (bidx & lmask(i_q));
    im1      = i_q - OW'(1);
    pidx     = SW'(base >> i_q);
    c0_addr  = rbase(im1) + ((pidx << 1) & lmask(im1));
    c1_addr  = rbase(im1) + (((pidx << 1) + SW'(1)) & lmask(im1));
    buddy    = (cur_q >> o_q) ^ PW'(1);
    buddy_page = buddy << o_q;
    buddy_addr = rbase(o_q) + (SW'(buddy) & lmask(o_q));
    onew     = o_q - OW'(1);
    sel_o    = (op_i == OP_SPLIT) ? onew : o_q;
    cnt_sel  = cnt_q[sel_o];
    head_sel = head_q[sel_o];
    case (op_i)
      OP_FIND:         sel_k = '0;
      OP_LRD, OP_SHWR: sel_k = k_q;
      OP_SHRD:         sel_k = k_q + NW'(1);
      default:         sel_k = cnt_sel;
    endcase
    slot     = rbase(sel_o) + ((SW'(head_sel) + SW'(sel_k)) & lmask(sel_o));
    full     = (cnt_sel >= lcap(sel_o));
    ordf     = clog2n(np_q);
    pagesf   = (NW+1)'(1) << ordf;
  end

  // status, independent of the current op
  always_comb begin
    st_o.clear_last = (clr_q == SW'(SLOTS - 1));
    st_o.kind_free  = (kind_q == KIND_FREE);
    st_o.size_zero  = (size_q == '0);
    st_o.ord_hit    = (CW'(size_q) <= (CW'(ps_eff) << i_q));
    st_o.i_top      = (int'(i_q) == ORDER);
    st_o.i_ord      = (i_q == want_q);
    st_o.j_wrap     = (j_inc == lim);
    st_o.list_nz    = (cnt_q[o_q] != '0);
    st_o.o_top      = (int'(o_q) == ORDER);
    st_o.o_gt_want  = (o_q > want_q);
    st_o.bit_set    = bm_rdata;
    st_o.free_bad   = (np_q == '0) || (int'(ordf) > ORDER) ||
                      (((NW+1)'(pid_q) & (pagesf - (NW+1)'(1))) != '0) ||
                      (((NW+1)'(pid_q) + pagesf) > (NW+1)'(POOL));
    st_o.k_end      = (k_q == cnt_q[o_q]);
    st_o.match      = (st_rdata == buddy_page);
    st_o.sh_more    = ((k_q + NW'(1)) < cnt_q[o_q]);
    st_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // RAM port selection
  always_comb begin
    st_we    = 1'b0;
    st_addr  = slot;
    st_wdata = cur_q;
    bm_we    = 1'b0;
    bm_waddr = bit_addr;
    bm_wdata = 1'b0;
    bm_raddr = bit_addr;
    case (op_i)
      OP_CLEAR: begin
        st_we    = 1'b1;
        st_addr  = rbase(OW'(ORDER));
        st_wdata = '0;
        bm_we    = 1'b1;
        bm_waddr = clr_q;
      end
      OP_SPLIT: begin
        st_we    = !full;
        st_wdata = cur_q + (PW'(1) << onew);
      end
      OP_SHWR: begin
        st_we    = 1'b1;
        st_wdata = st_rdata;
      end
      OP_PUSH:  st_we = !full;
      OP_MSET: begin
        bm_we    = 1'b1;
        bm_wdata = 1'b1;
      end
      OP_ICLR:  bm_we = 1'b1;
      OP_ICHK:  bm_we = !c0_q && !bm_rdata;
      OP_MGRD:  bm_raddr = buddy_addr;
      OP_IRD0:  bm_raddr = c0_addr;
      OP_IRD1:  bm_raddr = c1_addr;
      default: ;
    endcase
  end

  bpa_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_addr),
    .wdata_i (st_wdata),
    .raddr_i (st_addr),
    .rdata_o (st_rdata)
  );

  bpa_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_busy (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q        <= PS_RESET;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int n = 0; n <= ORDER; n++) begin
        head_q[n] <= '0;
        cnt_q[n]  <= (n == ORDER) ? NW'(1) : '0;
      end
    end else begin
      if (cfg_we_i) ps_q <= cfg_wdata_i;
      if (op_i == OP_CLEAR) clr_q <= clr_q + SW'(1);
      if (op_i == OP_EMIT) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (op_i)
        OP_POP: begin
          head_q[o_q] <= PW'((SW'(head_q[o_q]) + SW'(1)) & lmask(o_q));
          cnt_q[o_q]  <= cnt_q[o_q] - NW'(1);
        end
        OP_SPLIT:  if (!full) cnt_q[onew] <= cnt_q[onew] + NW'(1);
        OP_PUSH:   if (!full) cnt_q[o_q] <= cnt_q[o_q] + NW'(1);
        OP_RMDONE: cnt_q[o_q] <= cnt_q[o_q] - NW'(1);
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        kind_q <= in_word_i.kind;
        size_q <= in_word_i.size_bytes;
        pid_q  <= in_word_i.page_id;
        np_q   <= in_word_i.num_pages;
        i_q    <= '0;
        j_q    <= '0;
      end
      OP_ORD: begin
        if (st_o.ord_hit) begin
          want_q <= i_q;
          o_q    <= i_q;
        end else i_q <= i_q + OW'(1);
      end
      OP_FIND: if (cnt_q[o_q] == '0) o_q <= o_q + OW'(1);
      OP_POP: begin
        cur_q <= st_rdata;
        i_q   <= '0;
        j_q   <= '0;
      end
      OP_SPLIT: o_q <= onew;
      OP_MSET, OP_BNEXT, OP_ICLR: begin
        if (st_o.j_wrap) begin
          j_q <= '0;
          i_q <= i_q + OW'(1);
        end else j_q <= j_inc;
      end
      OP_FCHK: begin
        want_q <= ordf;
        o_q    <= ordf;
        cur_q  <= pid_q;
        i_q    <= '0;
        j_q    <= '0;
      end
      OP_MGRD:  k_q <= '0;
      OP_LNEXT, OP_SHWR: k_q <= k_q + NW'(1);
      OP_RMDONE: begin
        cur_q <= cur_q & ~(PW'(1) << o_q);
        o_q   <= o_q + OW'(1);
      end
      OP_PUSH: begin
        i_q <= '0;
        j_q <= '0;
      end
      OP_IRD1: c0_q <= bm_rdata;
      OP_ICHK: i_q <= i_q + OW'(1);
      OP_OK: begin
        res_q.ok          <= 1'b1;
        res_q.block_page  <= (kind_q == KIND_FREE) ? pid_q : cur_q;
        res_q.block_pages <= pages;
      end
      OP_FAIL:  res_q <= '0;
      OP_EMIT:  out_q <= res_q;
      default: ;
    endcase
  end

  assign out_word_o  = out_q;
  assign out_valid_o = out_valid_q;
  assign page_size_o = ps_q;

endmodule

// ===== hw/rtl/buddy_page_allocator.sv =====
// Top level of the buddy page allocator: sequencer, datapath, APB register.
// Depends on bpa_pkg, bpa_ctrl, bpa_dp, buddy_page_allocator_defines.svh.
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+-----------
//  in      | input     | in_valid_i / in_stall_o   | bpa_in_t
//  out     | output    | out_valid_o / out_stall_i | bpa_out_t
//  cfg     | input     | APB psel/penable/pready   | page_size
//
// After reset the busy bitmaps are cleared by a sweep over all 2^(ORDER+1) = 2048
// slots; in_stall_o is high until it ends. Config writes are taken anytime.
// One request at a time. Allocate: sizing, then a list search from the wanted
// order up to o, the order found, then splits down to the wanted order, then a
// busy-bit read per bit written plus the stopping bit (at most 2^(ORDER+1)-1 reads).
// Free: a read per bit checked, a scan and shift of the list entries per merge,
// then a write per bit cleared and a check per upper order. The bitmap RAM read
// port sets the pace. A finished word waits in the output register; while it is
// stalled the next request runs, and holds at the end until the slot frees.
`include "buddy_page_allocator_defines.svh"

module buddy_page_allocator import bpa_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  // request channel
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bpa_in_t       in_word_i,
  // result channel
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bpa_out_t      out_word_o,
  // APB register port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [DW-1:0] pwdata,
  output logic [DW-1:0] prdata,
  output logic          pready
);

  bpa_op_e        op;
  bpa_status_t    st;
  logic           cfg_we;
  logic [PSW-1:0] page_size;

  // only register 0 (page_size) exists; bit 2 selects word 1 and above
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? '0 : DW'(page_size);

  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .st_i       (st),
    .op_o       (op),
    .in_stall_o (in_stall_o)
  );

  bpa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .st_o        (st),
    .in_word_i   (in_word_i),
    .out_word_o  (out_word_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata[PSW-1:0]),
    .page_size_o (page_size)
  );

  // one request in flight: an accepted word blocks the next cycle
  `BPA_ASSERT_NEXT(a_one_inflight, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "second word accepted while busy")
  // a fresh result is loaded only on the way back to idle
  `BPA_ASSERT_NOW(a_emit_idle, clk_i, rst_ni, $rose(out_valid_o), !in_stall_o, "result loaded outside idle return")
  // granted blocks are a power of two pages
  `BPA_ASSERT_NOW(a_pow2, clk_i, rst_ni, out_valid_o && out_word_o.ok, $onehot(out_word_o.block_pages), "granted size not a power of two")
  // rejected requests carry zero fields
  `BPA_ASSERT_NOW(a_fail_zero, clk_i, rst_ni, out_valid_o && !out_word_o.ok, out_word_o.block_page == '0 && out_word_o.block_pages == '0, "reject word not zero")

endmodule

// ===== verif/buddy_page_allocator_tb.sv =====
// Testbench for the buddy page allocator: random and directed allocate/free
// requests checked against an in-bench model of the free lists and bitmaps.
// Depends on bpa_pkg and the buddy_page_allocator RTL.
`timescale 1ns / 100ps

module buddy_page_allocator_tb;
  import bpa_pkg::*;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic [AW-1:0] REG_PAGE_SIZE = AW'(0);
  localparam int WATCHDOG_LIMIT = 200000;

  // Result queue plus a model of the allocator state.
  class alloc_scoreboard;
    bpa_out_t    pending_q[$];
    int          errors;
    int unsigned page_bytes;
    int unsigned fl_store[SLOTS];
    int unsigned fl_head[ORDER+1];
    int unsigned fl_cnt[ORDER+1];
    bit          busy[SLOTS];
    int unsigned granted_page[$];
    int unsigned granted_pages[$];

    function new();
      errors = 0;
      page_bytes = 4096;
      foreach (fl_head[o]) begin
        fl_head[o] = 0;
        fl_cnt[o] = 0;
      end
      foreach (busy[i]) busy[i] = 0;
      fl_store[SLOTS-2] = 0;
      fl_cnt[ORDER] = 1;
    endfunction

    function int unsigned base_of(int unsigned o);
      return SLOTS - (2 << (ORDER - o));
    endfunction

    function int unsigned slot_of(int unsigned o, int unsigned k);
      return base_of(o) + ((fl_head[o] + k) & ((1 << (ORDER - o)) - 1));
    endfunction

    function void push_blk(int unsigned o, int unsigned pg);
      if (fl_cnt[o] >= (1 << (ORDER - o))) return;
      fl_store[slot_of(o, fl_cnt[o])] = pg;
      fl_cnt[o]++;
    endfunction

    function bit take_blk(int unsigned o, int unsigned pg);
      for (int unsigned k = 0; k < fl_cnt[o]; k++)
        if (fl_store[slot_of(o, k)] == pg) begin
          for (int unsigned m = k; m + 1 < fl_cnt[o]; m++)
            fl_store[slot_of(o, m)] = fl_store[slot_of(o, m + 1)];
          fl_cnt[o]--;
          return 1;
        end
      return 0;
    endfunction

    function bit busy_at(int unsigned o, int unsigned idx);
      return busy[base_of(o) + (idx & ((1 << (ORDER - o)) - 1))];
    endfunction

    function void set_busy(int unsigned o, int unsigned idx, bit v);
      busy[base_of(o) + (idx & ((1 << (ORDER - o)) - 1))] = v;
    endfunction

    function int unsigned log2_up(longint unsigned n);
      int unsigned o = 0;
      while (o < 40 && (64'd1 << o) < n) o++;
      return o;
    endfunction

    // Works out the result of one accepted request and queues it.
    function void note_request(bpa_in_t w);
      bpa_out_t r;
      r = '0;
      if (w.kind == KIND_ALLOC) begin
        longint unsigned sz, ps;
        int unsigned want, o, p, cnt;
        bit stop;
        sz = w.size_bytes;
        ps = (page_bytes == 0) ? 1 : page_bytes;
        if (sz != 0 && sz <= POOL * ps) begin
          want = log2_up((sz + ps - 1) / ps);
          o = want;
          while (o <= ORDER && fl_cnt[o] == 0) o++;
          if (o <= ORDER) begin
            p = fl_store[slot_of(o, 0)];
            fl_head[o] = (fl_head[o] + 1) & ((1 << (ORDER - o)) - 1);
            fl_cnt[o]--;
            while (o > want) begin
              o--;
              push_blk(o, p + (1 << o));
            end
            stop = 0;
            for (int unsigned i = 0; i <= ORDER && !stop; i++) begin
              cnt = (1 << want) >> i;
              if (cnt == 0) cnt = 1;
              for (int unsigned j = 0; j < cnt && !stop; j++) begin
                if (busy_at(i, (p >> i) + j)) stop = 1;
                else set_busy(i, (p >> i) + j, 1);
              end
            end
            r.ok = 1;
            r.block_page = PW'(p);
            r.block_pages = NW'(1 << want);
            granted_page.insert(granted_page.size(), p);
            granted_pages.insert(granted_pages.size(), 1 << want);
          end
        end
      end else begin
        int unsigned p, n, ord, pages, cur, o, bud, cnt, idx;
        bit good;
        p = w.page_id;
        n = w.num_pages;
        if (n != 0) begin
          ord = log2_up(n);
          if (ord <= ORDER) begin
            pages = 1 << ord;
            good = ((p & (pages - 1)) == 0) && (p + pages <= POOL);
            for (int unsigned i = 0; i <= ord && good; i++)
              for (int unsigned j = 0; j < (1 << (ord - i)); j++)
                if (!busy_at(i, (p >> i) + j)) good = 0;
            if (good) begin
              cur = p;
              o = ord;
              while (o < ORDER) begin
                bud = (cur >> o) ^ 1;
                if (busy_at(o, bud) || !take_blk(o, bud << o)) break;
                cur &= ~(1 << o);
                o++;
              end
              push_blk(o, cur);
              for (int unsigned i = 0; i <= ORDER; i++) begin
                cnt = pages >> i;
                idx = p >> i;
                if (cnt != 0) begin
                  for (int unsigned j = 0; j < cnt; j++) set_busy(i, idx + j, 0);
                end else if (!busy_at(i - 1, idx << 1) && !busy_at(i - 1, (idx << 1) + 1))
                  set_busy(i, idx, 0);
              end
              r.ok = 1;
              r.block_page = PW'(p);
              r.block_pages = NW'(pages);
            end
          end
        end
      end
      pending_q.insert(pending_q.size(), r);
    endfunction

    function void check_result(bpa_out_t got);
      bpa_out_t exp_w;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %p", got);
        return;
      end
      exp_w = pending_q[0];
      pending_q.delete(0);
      if (got !== exp_w) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected ok=%0d page=%0d pages=%0d, got ok=%0d page=%0d pages=%0d",
                   exp_w.ok, exp_w.block_page, exp_w.block_pages,
                   got.ok, got.block_page, got.block_pages);
      end
    endfunction
  endclass

  logic          clk_i = 0;
  logic          rst_ni = 0;
  logic          in_valid_i = 0;
  logic          in_stall_o;
  bpa_in_t       in_word_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 0;
  bpa_out_t      out_word_o;
  logic          psel = 0, penable = 0, pwrite = 0;
  logic [AW-1:0] paddr = '0;
  logic [DW-1:0] pwdata = '0;
  logic [DW-1:0] prdata;
  logic          pready;

  alloc_scoreboard sb = new();
  bit  calm;           // no idling on either side while set
  int  idle_cycles = 0;

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  buddy_page_allocator dut (.*);

  // Result side: random stall, check every accepted word.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_word_o);
    out_stall_i <= !calm && ($urandom_range(99) < 7);
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("buddy_page_allocator test failed");
      $finish;
    end
  end

  // Sends one request word, with a random gap first.
  task automatic send_word(bpa_in_t w);
    while (!calm && $urandom_range(99) < 7) @(posedge clk_i);
    in_valid_i <= 1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(w);
    in_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic alloc_req(logic [SZW-1:0] sz);
    bpa_in_t w;
    w = '0;
    w.kind = KIND_ALLOC;
    w.size_bytes = sz;
    w.page_id = PW'($urandom);
    w.num_pages = NW'($urandom);
    send_word(w);
  endtask

  task automatic free_req(int unsigned pg, int unsigned n);
    bpa_in_t w;
    w = '0;
    w.kind = KIND_FREE;
    w.size_bytes = $urandom;
    w.page_id = PW'(pg);
    w.num_pages = NW'(n);
    send_word(w);
  endtask

  // Waits for the result queue to drain, then lets the clock run on.
  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (5000) @(posedge clk_i);
  endtask

  task automatic write_page_size(int unsigned v);
    psel <= 1; pwrite <= 1; paddr <= REG_PAGE_SIZE; pwdata <= DW'(v);
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.page_bytes = v & 32'h1FFFF;
  endtask

  // Frees a previously granted block, sometimes with a smaller count that rounds up to the same size.
  task automatic free_granted();
    int unsigned k, pg, n;
    k = $urandom_range(sb.granted_page.size() - 1);
    pg = sb.granted_page[k];
    n = sb.granted_pages[k];
    sb.granted_page.delete(k);
    sb.granted_pages.delete(k);
    if (n > 2 && $urandom_range(1)) n = n / 2 + 1;
    free_req(pg, n);
  endtask

  task automatic random_phase(int unsigned count);
    int unsigned r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 45) begin
        case ($urandom_range(3))
          0: alloc_req($urandom);
          1: alloc_req($urandom_range(sb.page_bytes * 16 + 1, 1));
          default: alloc_req($urandom_range(sb.page_bytes * 128 + 1, 1));
        endcase
      end else if (r < 85 && sb.granted_page.size() != 0)
        free_granted();
      else
        free_req($urandom_range(1023), $urandom_range(1024));
    end
  endtask

  initial begin
    calm = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes, empty pool, bad frees, double free, merges.
    alloc_req(0);
    alloc_req(32'hFFFF_FFFF);
    alloc_req(POOL * 4096 + 1);
    alloc_req(POOL * 4096);     // whole pool
    alloc_req(1);               // pool empty
    free_req(0, 0);             // zero pages
    free_req(0, 2047);          // oversized
    free_req(1, 2);             // unaligned
    free_req(1023, 1024);
    free_req(0, 1024);          // whole pool back
    free_req(0, 1024);          // not busy anymore
    alloc_req(4096);
    alloc_req(4097);
    alloc_req(3 * 4096);
    free_req(512, 512);         // not busy
    free_req(1023, 1);
    free_req(0, 1);
    free_req(1, 1);
    free_req(2, 2);
    free_req(4, 3);
    alloc_req(1);
    drain();
    sb.granted_page.delete();
    sb.granted_pages.delete();

    // Settings walk: zero is treated as one, then the largest, one, a random size and 4096.
    write_page_size(0);
    alloc_req(1); alloc_req(1024); alloc_req(1025); free_req(0, 1);
    random_phase(100);
    drain();
    write_page_size(32'h1FFFF);
    alloc_req(32'hFFFF_FFFF); alloc_req(65536 * 3);
    random_phase(100);
    drain();
    write_page_size(1);
    random_phase(150);
    drain();                    // sender holds off until all results are in
    write_page_size($urandom_range(65536, 1));
    calm = 1;                   // stretch with no idling
    random_phase(200);
    calm = 0;
    drain();
    write_page_size(4096);
    random_phase(350);

    drain();
    if (sb.errors == 0)
      $display("buddy_page_allocator test passed");
    else
      $display("buddy_page_allocator test failed");
    $finish;
  end

endmodule
